// ===== src/hwg_pkg.sv =====
// ----------------------------------------------------------------------------
// hwg_pkg
// Shared types, codes and default sizes for the hidden weight gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package hwg_pkg;

  // default sizing of the operand stores
  localparam int MAX_SAMPLES_DEF = 256;
  localparam int MAX_HIDDEN_DEF  = 16;
  localparam int MAX_CLASSES_DEF = 8;

  // rounding point of the scaled class term (Q.60 down to Q.16)
  localparam int FRAC_DROP = 44;

  // input operation codes
  typedef enum logic [2:0] {
    OP_WR_ERR   = 3'd0,
    OP_WR_DERIV = 3'd1,
    OP_WR_ACT   = 3'd2,
    OP_WR_WGT   = 3'd3,
    OP_COMPUTE  = 3'd4,
    OP_RD_GRAD  = 3'd5
  } op_t;

  // result kinds
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_SAMPLES = 3'd0;
  localparam logic [2:0] REG_HIDDEN  = 3'd1;
  localparam logic [2:0] REG_CLASSES = 3'd2;
  localparam logic [2:0] REG_GAIN    = 3'd3;
  localparam logic [2:0] REG_ROWSEL  = 3'd4;

  localparam int CFG_AW = 5;

  typedef struct packed {
    logic [2:0]         op;
    logic [11:0]        addr;
    logic signed [15:0] data;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] grad_value;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       start;
    logic       issue;
    logic       first;
    logic       last;
    logic       scale;
    logic       mstep_v;
    logic [1:0] mstep;
    logic       round;
    logic       accum;
    logic       acc_first;
    logic       write;
    logic       done_push;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sum_done;
    logic rd_pend;
    logic out_free;
  } status_t;

  // address width for a store of n entries, never below one bit
  function automatic int aw(input int n);
    return (n <= 2) ? 1 : $clog2(n);
  endfunction

endpackage

`default_nettype wire

// ===== src/hidden_weight_gradient.sv =====
// ----------------------------------------------------------------------------
// hidden_weight_gradient
// Hidden-layer weight gradient engine: operand stores, compute sequencer
// and gradient store behind a valid/stall command channel.
// ----------------------------------------------------------------------------
// Usage:
//  - Input transactions carry op, addr and data. Ops 0..3 load the error,
//    derivative, activation and weight stores, one per cycle while in_stall is low.
//  - Op 5 reads a gradient entry via the read and result registers;
//    reads stream one per cycle while the receiver keeps up.
//  - Op 4 starts a compute. Input is held off while it runs; then a single
//    "finished" result (kind 0, value 0) is returned.
//  - Compute time is set by the sample loop, which reads one sample of
//    each operand store per cycle.
//  - A stalled receiver holds the result register; a following read then
//    waits in the read register and the input stalls behind it.
//  - Reset (rst_n low, synchronous) restores the register defaults, empties
//    the result path and marks every gradient entry as zero. Operand
//    stores are left as they are and must be loaded before use.
//  - Write configuration over the cfg_ APB port only while idle (unenforced).
// ----------------------------------------------------------------------------
`default_nettype none

module hidden_weight_gradient #(
  parameter int MAX_SAMPLES = hwg_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_HIDDEN  = hwg_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_CLASSES = hwg_pkg::MAX_CLASSES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // command channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire hwg_pkg::in_item_t           in_data,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output hwg_pkg::out_item_t               out_data,
  // configuration port
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [hwg_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic      [31:0]                 cfg_prdata,
  output logic                             cfg_pready
);

  localparam int KW  = hwg_pkg::aw(MAX_SAMPLES + 1);
  localparam int HW  = hwg_pkg::aw(MAX_HIDDEN + 1);
  localparam int CW  = hwg_pkg::aw(MAX_CLASSES + 1);
  localparam int EAW = hwg_pkg::aw(MAX_CLASSES * MAX_SAMPLES);
  localparam int HAW = hwg_pkg::aw(MAX_HIDDEN * MAX_SAMPLES);
  localparam int WAW = hwg_pkg::aw(MAX_HIDDEN * MAX_CLASSES);
  localparam int GAW = hwg_pkg::aw(MAX_HIDDEN * MAX_HIDDEN);

  logic [KW-1:0]    k_eff;
  logic [HW-1:0]    h_eff, row_from, row_to;
  logic [CW-1:0]    c_eff;
  logic [15:0]      gain;
  hwg_pkg::cmd_t    cmd;
  hwg_pkg::status_t st;
  logic [EAW-1:0]   err_ra;
  logic [HAW-1:0]   der_ra, act_ra;
  logic [WAW-1:0]   wgt_ra;
  logic [GAW-1:0]   grd_wa;

  // the register file never inserts wait states
  assign cfg_pready = 1'b1;

  hwg_regs #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_HIDDEN  (MAX_HIDDEN),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .k_eff    (k_eff),
    .h_eff    (h_eff),
    .c_eff    (c_eff),
    .gain     (gain),
    .row_from (row_from),
    .row_to   (row_to)
  );

  // sequencer: accepts transactions, walks rows, columns, classes, samples
  hwg_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_HIDDEN  (MAX_HIDDEN),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .k_eff    (k_eff),
    .h_eff    (h_eff),
    .c_eff    (c_eff),
    .row_from (row_from),
    .row_to   (row_to),
    .st       (st),
    .cmd      (cmd),
    .err_ra   (err_ra),
    .der_ra   (der_ra),
    .act_ra   (act_ra),
    .wgt_ra   (wgt_ra),
    .grd_wa   (grd_wa)
  );

  // datapath: stores, MAC pipe, scaling and the result register
  hwg_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_HIDDEN  (MAX_HIDDEN),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .k_eff     (k_eff),
    .gain      (gain),
    .err_ra    (err_ra),
    .der_ra    (der_ra),
    .act_ra    (act_ra),
    .wgt_ra    (wgt_ra),
    .grd_wa    (grd_wa),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/hwg_regs.sv =====
// ----------------------------------------------------------------------------
// hwg_regs
// Configuration registers and the effective, clamped loop bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module hwg_regs #(
  parameter int MAX_SAMPLES = hwg_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_HIDDEN  = hwg_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_CLASSES = hwg_pkg::MAX_CLASSES_DEF,
  localparam int KW = hwg_pkg::aw(MAX_SAMPLES + 1),
  localparam int HW = hwg_pkg::aw(MAX_HIDDEN + 1),
  localparam int CW = hwg_pkg::aw(MAX_CLASSES + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hwg_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic      [KW-1:0]               k_eff,
  output logic      [HW-1:0]               h_eff,
  output logic      [CW-1:0]               c_eff,
  output logic      [15:0]                 gain,
  output logic      [HW-1:0]               row_from,
  output logic      [HW-1:0]               row_to
);

  logic [8:0]  samples_r;
  logic [4:0]  hidden_r;
  logic [3:0]  classes_r;
  logic [15:0] gain_r;
  logic [4:0]  rowsel_r;
  logic [2:0]  idx;
  logic        wr;

  assign idx = paddr[4:2];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= 9'd256;
      hidden_r  <= 5'd16;
      classes_r <= 4'd8;
      gain_r    <= 16'd512;
      rowsel_r  <= 5'd0;
    end else if (wr) begin
      unique case (idx)
        hwg_pkg::REG_SAMPLES: samples_r <= pwdata[8:0];
        hwg_pkg::REG_HIDDEN:  hidden_r  <= pwdata[4:0];
        hwg_pkg::REG_CLASSES: classes_r <= pwdata[3:0];
        hwg_pkg::REG_GAIN:    gain_r    <= pwdata[15:0];
        hwg_pkg::REG_ROWSEL:  rowsel_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hwg_pkg::REG_SAMPLES: prdata = 32'(samples_r);
      hwg_pkg::REG_HIDDEN:  prdata = 32'(hidden_r);
      hwg_pkg::REG_CLASSES: prdata = 32'(classes_r);
      hwg_pkg::REG_GAIN:    prdata = 32'(gain_r);
      hwg_pkg::REG_ROWSEL:  prdata = 32'(rowsel_r);
      default:              prdata = 32'd0;
    endcase
  end

  // clamp counts into 1..max
  always_comb begin
    priority if (samples_r == 9'd0)            k_eff = KW'(1);
    else if (int'(samples_r) > MAX_SAMPLES)    k_eff = KW'(MAX_SAMPLES);
    else                                       k_eff = KW'(samples_r);
    priority if (hidden_r == 5'd0)             h_eff = HW'(1);
    else if (int'(hidden_r) > MAX_HIDDEN)      h_eff = HW'(MAX_HIDDEN);
    else                                       h_eff = HW'(hidden_r);
    priority if (classes_r == 4'd0)            c_eff = CW'(1);
    else if (int'(classes_r) > MAX_CLASSES)    c_eff = CW'(MAX_CLASSES);
    else                                       c_eff = CW'(classes_r);
  end

  // a row outside the hidden count selects all rows
  always_comb begin
    if (rowsel_r != 5'd0 && (int'(rowsel_r) - 1) < int'(h_eff)) begin
      row_from = HW'(int'(rowsel_r) - 1);
      row_to   = HW'(rowsel_r);
    end else begin
      row_from = '0;
      row_to   = h_eff;
    end
  end

  assign gain = gain_r;

endmodule

`default_nettype wire

// ===== src/hwg_ctrl.sv =====
// ----------------------------------------------------------------------------
// hwg_ctrl
// Sequencer: input handshake, loop counters and store address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module hwg_ctrl #(
  parameter int MAX_SAMPLES = hwg_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_HIDDEN  = hwg_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_CLASSES = hwg_pkg::MAX_CLASSES_DEF,
  localparam int KW  = hwg_pkg::aw(MAX_SAMPLES + 1),
  localparam int HW  = hwg_pkg::aw(MAX_HIDDEN + 1),
  localparam int CW  = hwg_pkg::aw(MAX_CLASSES + 1),
  localparam int EAW = hwg_pkg::aw(MAX_CLASSES * MAX_SAMPLES),
  localparam int HAW = hwg_pkg::aw(MAX_HIDDEN * MAX_SAMPLES),
  localparam int WAW = hwg_pkg::aw(MAX_HIDDEN * MAX_CLASSES),
  localparam int GAW = hwg_pkg::aw(MAX_HIDDEN * MAX_HIDDEN)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [2:0]       in_op,
  output logic                  in_stall,
  input  wire logic [KW-1:0]    k_eff,
  input  wire logic [HW-1:0]    h_eff,
  input  wire logic [CW-1:0]    c_eff,
  input  wire logic [HW-1:0]    row_from,
  input  wire logic [HW-1:0]    row_to,
  input  wire hwg_pkg::status_t st,
  output hwg_pkg::cmd_t         cmd,
  output logic      [EAW-1:0]   err_ra,
  output logic      [HAW-1:0]   der_ra,
  output logic      [HAW-1:0]   act_ra,
  output logic      [WAW-1:0]   wgt_ra,
  output logic      [GAW-1:0]   grd_wa
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_START = 10'b0000000010,
    S_ISSUE = 10'b0000000100,
    S_DRAIN = 10'b0000001000,
    S_MULT  = 10'b0000010000,
    S_MWAIT = 10'b0000100000,
    S_ROUND = 10'b0001000000,
    S_ACC   = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [KW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [HW-1:0]   k_r, k_nxt;
  logic [HW-1:0]   h_r, h_nxt;
  logic [HW-1:0]   hend_r, hend_nxt;
  logic [1:0]      ms_r, ms_nxt;
  logic [EAW-1:0]  eb_r, eb_nxt;
  logic [HAW-1:0]  db_r, db_nxt;
  logic [HAW-1:0]  ab_r, ab_nxt;
  logic [WAW-1:0]  wa_r, wa_nxt;
  logic [GAW-1:0]  ga_r, ga_nxt;
  logic            accept;

  assign in_stall = (state_r != S_IDLE) | (st.rd_pend & ~st.out_free);
  assign accept   = in_valid & ~in_stall;

  assign err_ra = eb_r + EAW'(i_r);
  assign der_ra = db_r + HAW'(i_r);
  assign act_ra = ab_r + HAW'(i_r);
  assign wgt_ra = wa_r;
  assign grd_wa = ga_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    h_nxt     = h_r;
    hend_nxt  = hend_r;
    ms_nxt    = ms_r;
    eb_nxt    = eb_r;
    db_nxt    = db_r;
    ab_nxt    = ab_r;
    wa_nxt    = wa_r;
    ga_nxt    = ga_r;
    cmd       = '0;
    cmd.accept = accept;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == hwg_pkg::OP_COMPUTE) state_nxt = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        h_nxt     = row_from;
        hend_nxt  = row_to;
        db_nxt    = HAW'(row_from * k_eff);
        ga_nxt    = GAW'(row_from * h_eff);
        wa_nxt    = WAW'(row_from);
        i_nxt     = '0;
        j_nxt     = '0;
        k_nxt     = '0;
        eb_nxt    = '0;
        ab_nxt    = '0;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.first = (i_r == '0);
        cmd.last  = (i_r == KW'(k_eff - KW'(1)));
        if (cmd.last) begin
          i_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + KW'(1);
        end
      end
      S_DRAIN: begin
        // wait for the sample sum to leave the MAC pipe
        if (st.sum_done) begin
          cmd.scale = 1'b1;
          ms_nxt    = '0;
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mstep_v = 1'b1;
        cmd.mstep   = ms_r;
        ms_nxt      = ms_r + 2'd1;
        if (ms_r == 2'd3) state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accum     = 1'b1;
        cmd.acc_first = (j_r == '0);
        if (j_r == CW'(c_eff - CW'(1))) begin
          state_nxt = S_WRITE;
        end else begin
          j_nxt     = j_r + CW'(1);
          eb_nxt    = eb_r + EAW'(k_eff);
          wa_nxt    = wa_r + WAW'(h_eff);
          state_nxt = S_ISSUE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        ga_nxt    = ga_r + GAW'(1);
        j_nxt     = '0;
        eb_nxt    = '0;
        state_nxt = S_ISSUE;
        if (k_r == HW'(h_eff - HW'(1))) begin
          if (h_r == HW'(hend_r - HW'(1))) begin
            state_nxt = S_DONE;
          end else begin
            h_nxt  = h_r + HW'(1);
            db_nxt = db_r + HAW'(k_eff);
            k_nxt  = '0;
            ab_nxt = '0;
            wa_nxt = WAW'(h_r + HW'(1));
          end
        end else begin
          k_nxt  = k_r + HW'(1);
          ab_nxt = ab_r + HAW'(k_eff);
          wa_nxt = WAW'(h_r);
        end
      end
      S_DONE: begin
        if (st.out_free && !st.rd_pend) begin
          cmd.done_push = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      h_r     <= '0;
      hend_r  <= '0;
      ms_r    <= '0;
      eb_r    <= '0;
      db_r    <= '0;
      ab_r    <= '0;
      wa_r    <= '0;
      ga_r    <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      h_r     <= h_nxt;
      hend_r  <= hend_nxt;
      ms_r    <= ms_nxt;
      eb_r    <= eb_nxt;
      db_r    <= db_nxt;
      ab_r    <= ab_nxt;
      wa_r    <= wa_nxt;
      ga_r    <= ga_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/hwg_dp.sv =====
// ----------------------------------------------------------------------------
// hwg_dp
// Operand and gradient stores, sample MAC pipe, scaling multiplier and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hwg_dp #(
  parameter int MAX_SAMPLES = hwg_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_HIDDEN  = hwg_pkg::MAX_HIDDEN_DEF,
  parameter int MAX_CLASSES = hwg_pkg::MAX_CLASSES_DEF,
  localparam int KW  = hwg_pkg::aw(MAX_SAMPLES + 1),
  localparam int EAW = hwg_pkg::aw(MAX_CLASSES * MAX_SAMPLES),
  localparam int HAW = hwg_pkg::aw(MAX_HIDDEN * MAX_SAMPLES),
  localparam int WAW = hwg_pkg::aw(MAX_HIDDEN * MAX_CLASSES),
  localparam int GAW = hwg_pkg::aw(MAX_HIDDEN * MAX_HIDDEN)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hwg_pkg::cmd_t      cmd,
  output hwg_pkg::status_t        st,
  input  wire hwg_pkg::in_item_t  in_data,
  input  wire logic [KW-1:0]      k_eff,
  input  wire logic [15:0]        gain,
  input  wire logic [EAW-1:0]     err_ra,
  input  wire logic [HAW-1:0]     der_ra,
  input  wire logic [HAW-1:0]     act_ra,
  input  wire logic [WAW-1:0]     wgt_ra,
  input  wire logic [GAW-1:0]     grd_wa,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output hwg_pkg::out_item_t      out_data
);

  localparam int ERR_DEPTH = MAX_CLASSES * MAX_SAMPLES;
  localparam int HID_DEPTH = MAX_HIDDEN * MAX_SAMPLES;
  localparam int WGT_DEPTH = MAX_HIDDEN * MAX_CLASSES;
  localparam int GRD_DEPTH = MAX_HIDDEN * MAX_HIDDEN;
  localparam int SW  = 46 + KW;                 // sample sum
  localparam int MW  = KW + 32;                 // K * gain * |w|
  localparam int PW  = SW + MW;                 // full scaled product
  localparam int MGW = PW + 1 - hwg_pkg::FRAC_DROP;
  localparam int ACW = MGW + 1 + hwg_pkg::aw(MAX_CLASSES + 1);
  localparam logic signed [ACW-1:0] SAT_HI = ACW'(64'sd2147483647);
  localparam logic signed [ACW-1:0] SAT_LO = -SAT_HI - ACW'(1);

  logic signed [15:0] err_mem [ERR_DEPTH];
  logic signed [15:0] der_mem [HID_DEPTH];
  logic signed [15:0] act_mem [HID_DEPTH];
  logic signed [15:0] wgt_mem [WGT_DEPTH];
  logic signed [31:0] grd_mem [GRD_DEPTH];
  logic [GRD_DEPTH-1:0] gvalid_r;

  logic               ld;
  logic [2:0]         op;
  logic signed [15:0] err_rd_r, der_rd_r, act_rd_r, wgt_rd_r;
  logic               v1_r, f1_r, l1_r, v2_r, f2_r, l2_r, v3_r, f3_r, l3_r;
  logic signed [31:0] p1_r;
  logic signed [15:0] a2_r;
  logic signed [47:0] p2_r;
  logic signed [SW-1:0] s_r;
  logic               sum_done_r;
  logic [KW+15:0]     km_r;
  logic [15:0]        wabs;
  logic [SW-1:0]      sm_r;
  logic [MW-1:0]      m_r;
  logic               neg_r;
  logic [63:0]        sm64, m64;
  logic [31:0]        ca, cb;
  logic [63:0]        pp_r;
  logic [1:0]         psh_r;
  logic               ppv_r;
  logic [PW-1:0]      prod_r;
  logic [PW:0]        rsum;
  logic [MGW-1:0]     mag_r;
  logic signed [ACW-1:0] term, acc_r;
  logic signed [31:0] sat;
  logic               rd_en, rd_move, out_free;
  logic [GAW-1:0]     rd_idx;
  logic signed [31:0] g_rd_r;
  logic               rd_ok_r, rd_pend_r, rd_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  hwg_pkg::out_item_t out_r;

  assign ld = cmd.accept;
  assign op = in_data.op;

  // operand stores: loads in idle, reads while issuing samples
  always_ff @(posedge clk) begin
    if (ld && op == hwg_pkg::OP_WR_ERR && int'(in_data.addr) < ERR_DEPTH)
      err_mem[EAW'(in_data.addr)] <= in_data.data;
    if (cmd.issue) err_rd_r <= err_mem[err_ra];
  end

  always_ff @(posedge clk) begin
    if (ld && op == hwg_pkg::OP_WR_DERIV && int'(in_data.addr) < HID_DEPTH)
      der_mem[HAW'(in_data.addr)] <= in_data.data;
    if (cmd.issue) der_rd_r <= der_mem[der_ra];
  end

  always_ff @(posedge clk) begin
    if (ld && op == hwg_pkg::OP_WR_ACT && int'(in_data.addr) < HID_DEPTH)
      act_mem[HAW'(in_data.addr)] <= in_data.data;
    if (cmd.issue) act_rd_r <= act_mem[act_ra];
  end

  always_ff @(posedge clk) begin
    if (ld && op == hwg_pkg::OP_WR_WGT && int'(in_data.addr) < WGT_DEPTH)
      wgt_mem[WAW'(in_data.addr)] <= in_data.data;
    if (cmd.issue) wgt_rd_r <= wgt_mem[wgt_ra];
  end

  // MAC pipe control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; sum_done_r <= 1'b0;
      f1_r <= 1'b0; f2_r <= 1'b0; f3_r <= 1'b0;
      l1_r <= 1'b0; l2_r <= 1'b0; l3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue; f1_r <= cmd.first; l1_r <= cmd.last;
      v2_r <= v1_r;      f2_r <= f1_r;      l2_r <= l1_r;
      v3_r <= v2_r;      f3_r <= f2_r;      l3_r <= l2_r;
      sum_done_r <= v3_r & l3_r;
    end
  end

  // MAC pipe data
  always_ff @(posedge clk) begin
    p1_r <= err_rd_r * der_rd_r;
    a2_r <= act_rd_r;
    p2_r <= p1_r * a2_r;
    if (v3_r) s_r <= f3_r ? SW'(p2_r) : s_r + SW'(p2_r);
  end

  // scale: sign-magnitude split, then four 32x32 partial products
  assign wabs = wgt_rd_r[15] ? 16'(-wgt_rd_r) : 16'(wgt_rd_r);
  assign sm64 = 64'(sm_r);
  assign m64  = 64'(m_r);
  assign ca   = cmd.mstep[1] ? sm64[63:32] : sm64[31:0];
  assign cb   = cmd.mstep[0] ? m64[63:32]  : m64[31:0];
  assign rsum = (PW+1)'(prod_r) + ((PW+1)'(1) << (hwg_pkg::FRAC_DROP - 1));

  always_comb begin
    term = ACW'(mag_r);
    if (neg_r) term = -term;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) km_r <= (KW+16)'(k_eff * gain);
    if (cmd.scale) begin
      sm_r  <= s_r[SW-1] ? SW'(-s_r) : SW'(s_r);
      neg_r <= s_r[SW-1] ^ wgt_rd_r[15];
      m_r   <= MW'(km_r * wabs);
    end
    pp_r  <= ca * cb;
    psh_r <= 2'(cmd.mstep[0]) + 2'(cmd.mstep[1]);
    if (cmd.scale)     prod_r <= '0;
    else if (ppv_r)    prod_r <= prod_r + (PW'(pp_r) << {psh_r, 5'b0});
    if (cmd.round)     mag_r <= rsum[PW:hwg_pkg::FRAC_DROP];
    if (cmd.accum)     acc_r <= cmd.acc_first ? term : acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ppv_r <= 1'b0;
    else        ppv_r <= cmd.mstep_v;
  end

  // saturate to Q15.16
  always_comb begin
    priority if (acc_r > SAT_HI) sat = 32'sh7fffffff;
    else if (acc_r < SAT_LO)     sat = 32'sh80000000;
    else                         sat = 32'(acc_r);
  end

  // gradient store; entries never written read as zero
  assign rd_en  = ld && op == hwg_pkg::OP_RD_GRAD;
  assign rd_idx = GAW'(in_data.addr);

  always_ff @(posedge clk) begin
    if (cmd.write) grd_mem[grd_wa] <= sat;
    if (rd_en) begin
      g_rd_r  <= grd_mem[rd_idx];
      rd_ok_r <= (int'(in_data.addr) < GRD_DEPTH) && gvalid_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         gvalid_r <= '0;
    else if (cmd.write) gvalid_r[grd_wa] <= 1'b1;
  end

  // result register
  assign out_free = ~out_valid_r | ~out_stall;
  assign rd_move  = rd_pend_r & out_free;

  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (rd_en)        rd_pend_nxt = 1'b1;
    else if (rd_move) rd_pend_nxt = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    if (rd_move || cmd.done_push) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      out_r.kind       <= hwg_pkg::KIND_READ;
      out_r.grad_value <= rd_ok_r ? g_rd_r : 32'sd0;
    end else if (cmd.done_push) begin
      out_r.kind       <= hwg_pkg::KIND_DONE;
      out_r.grad_value <= 32'sd0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign st.sum_done = sum_done_r;
  assign st.rd_pend  = rd_pend_r;
  assign st.out_free = out_free;

endmodule

`default_nettype wire

// ===== test/tb_hidden_weight_gradient.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hidden_weight_gradient
// Self-checking bench for the hidden weight gradient engine. A short table of
// directed commands runs first, then random load/compute/read traffic across
// many register settings. Every result is checked against a local model.
// ----------------------------------------------------------------------------
module tb_hidden_weight_gradient;

  // spare op codes: the block must ignore them
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int ERR_DEPTH = 2048;
  localparam int HID_DEPTH = 4096;
  localparam int WGT_DEPTH = 128;
  localparam int GRD_DEPTH = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hwg_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hwg_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [hwg_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  hidden_weight_gradient dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the engine: operand stores, written flags, gradient store
  // and the five registers, kept in step with every accepted transaction.
  // ---------------------------------------------------------------------------
  shortint err_mem[ERR_DEPTH];
  shortint der_mem[HID_DEPTH];
  shortint act_mem[HID_DEPTH];
  shortint wgt_mem[WGT_DEPTH];
  int      grad_mem[GRD_DEPTH];
  bit      err_set[ERR_DEPTH];
  bit      der_set[HID_DEPTH];
  bit      act_set[HID_DEPTH];
  bit      wgt_set[WGT_DEPTH];

  logic [8:0]  samples_reg = 9'd256;
  logic [4:0]  hidden_reg  = 5'd16;
  logic [3:0]  classes_reg = 4'd8;
  logic [15:0] gain_reg    = 16'd512;
  logic [4:0]  rowsel_reg  = 5'd0;

  hwg_pkg::out_item_t grad_results_q[$];
  hwg_pkg::out_item_t want;
  int fails = 0;
  int sent = 0;      // input transactions taken so far
  bit calm = 1'b0;   // true while neither side may idle

  function automatic int clamp_cnt(input int v, input int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int eff_k();
    return clamp_cnt(samples_reg, hwg_pkg::MAX_SAMPLES_DEF);
  endfunction

  function automatic int eff_h();
    return clamp_cnt(hidden_reg, hwg_pkg::MAX_HIDDEN_DEF);
  endfunction

  function automatic int eff_c();
    return clamp_cnt(classes_reg, hwg_pkg::MAX_CLASSES_DEF);
  endfunction

  // rows touched by a compute: one row if the select names a real row, else all
  task automatic row_span(output int lo, output int hi);
    lo = 0;
    hi = eff_h();
    if (rowsel_reg != 0 && rowsel_reg - 1 < eff_h()) begin
      lo = rowsel_reg - 1;
      hi = lo + 1;
    end
  endtask

  // Contract the operand stores into the gradient store. The sample sum is
  // exact; each class term is rounded from Q.60 to Q.16 (ties away from zero)
  // before the class terms add, and the total saturates to 32 bits.
  task automatic compute_gradients();
    int k_n, h_n, c_n, lo, hi, h, k, j, i;
    longint s, w, acc;
    logic [63:0] sm, m, mag;
    logic [127:0] p;
    bit neg;
    k_n = eff_k();
    h_n = eff_h();
    c_n = eff_c();
    row_span(lo, hi);
    for (h = lo; h < hi; h++) begin
      for (k = 0; k < h_n; k++) begin
        acc = 0;
        for (j = 0; j < c_n; j++) begin
          s = 0;
          w = wgt_mem[h + j * h_n];
          for (i = 0; i < k_n; i++)
            s += longint'(err_mem[i + j * k_n]) * longint'(der_mem[i + h * k_n])
                 * longint'(act_mem[i + k * k_n]);
          neg = (s < 0) != (w < 0);
          sm = (s < 0) ? -s : s;
          m = 64'(k_n) * 64'(gain_reg) * 64'((w < 0) ? -w : w);
          p = {64'd0, sm} * {64'd0, m};
          p = p + (128'd1 << 43);
          mag = p[107:44];
          acc += neg ? -longint'(mag) : longint'(mag);
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        grad_mem[k + h * h_n] = int'(acc);
      end
    end
  endtask

  // update the local copy for one accepted command, queue any result it owes
  task automatic predict_item(input hwg_pkg::in_item_t it);
    case (it.op)
      hwg_pkg::OP_WR_ERR:   if (it.addr < ERR_DEPTH) begin
        err_mem[it.addr] = it.data;
        err_set[it.addr] = 1'b1;
      end
      hwg_pkg::OP_WR_DERIV: begin
        der_mem[it.addr] = it.data;
        der_set[it.addr] = 1'b1;
      end
      hwg_pkg::OP_WR_ACT:   begin
        act_mem[it.addr] = it.data;
        act_set[it.addr] = 1'b1;
      end
      hwg_pkg::OP_WR_WGT:   if (it.addr < WGT_DEPTH) begin
        wgt_mem[it.addr] = it.data;
        wgt_set[it.addr] = 1'b1;
      end
      hwg_pkg::OP_COMPUTE: begin
        compute_gradients();
        grad_results_q.push_back('{kind: hwg_pkg::KIND_DONE, grad_value: 32'sd0});
      end
      hwg_pkg::OP_RD_GRAD:
        grad_results_q.push_back('{kind: hwg_pkg::KIND_READ,
          grad_value: (it.addr < GRD_DEPTH) ? grad_mem[it.addr] : 32'sd0});
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Command side: optional random gap, then hold the transaction until taken.
  // ---------------------------------------------------------------------------
  task automatic send_item(input hwg_pkg::in_item_t it, input bit typed);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
    predict_item(it);
    // directed rows with an obvious answer replace the predicted value
    if (typed)
      grad_results_q[$] = '{kind: (it.op == hwg_pkg::OP_COMPUTE) ?
                                  hwg_pkg::KIND_DONE : hwg_pkg::KIND_READ,
                            grad_value: 32'sd0};
  endtask

  // drop valid, let every result arrive, then let trailing writes settle
  task automatic drain();
    in_valid <= 1'b0;
    while (grad_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      hwg_pkg::REG_SAMPLES: samples_reg = value[8:0];
      hwg_pkg::REG_HIDDEN:  hidden_reg  = value[4:0];
      hwg_pkg::REG_CLASSES: classes_reg = value[3:0];
      hwg_pkg::REG_GAIN:    gain_reg    = value[15:0];
      hwg_pkg::REG_ROWSEL:  rowsel_reg  = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int k_v, input int h_v, input int c_v,
                            input int g_v, input int r_v);
    cfg_write(hwg_pkg::REG_SAMPLES, k_v);
    cfg_write(hwg_pkg::REG_HIDDEN, h_v);
    cfg_write(hwg_pkg::REG_CLASSES, c_v);
    cfg_write(hwg_pkg::REG_GAIN, g_v);
    cfg_write(hwg_pkg::REG_ROWSEL, r_v);
  endtask

  // operand values lean towards the Q2.13 extremes
  function automatic logic [15:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic hwg_pkg::in_item_t make_item(input logic [2:0] op, input int addr);
    hwg_pkg::in_item_t it;
    it.op   = op;
    it.addr = addr;
    it.data = rand_operand();
    return it;
  endfunction

  // load every operand the next compute will read that has never been written
  task automatic fill_operands();
    int k_n, h_n, c_n, lo, hi, h, j, i;
    k_n = eff_k();
    h_n = eff_h();
    c_n = eff_c();
    row_span(lo, hi);
    for (j = 0; j < c_n; j++)
      for (i = 0; i < k_n; i++)
        if (!err_set[i + j * k_n])
          send_item(make_item(hwg_pkg::OP_WR_ERR, i + j * k_n), 1'b0);
    for (h = 0; h < h_n; h++)
      for (i = 0; i < k_n; i++) begin
        if (h >= lo && h < hi && !der_set[i + h * k_n])
          send_item(make_item(hwg_pkg::OP_WR_DERIV, i + h * k_n), 1'b0);
        if (!act_set[i + h * k_n])
          send_item(make_item(hwg_pkg::OP_WR_ACT, i + h * k_n), 1'b0);
      end
    for (h = lo; h < hi; h++)
      for (j = 0; j < c_n; j++)
        if (!wgt_set[h + j * h_n])
          send_item(make_item(hwg_pkg::OP_WR_WGT, h + j * h_n), 1'b0);
  endtask

  // one random command; mostly loads inside the live layout, some reads,
  // a few computes, and the odd stray address or spare op code
  function automatic hwg_pkg::in_item_t random_item();
    int r, k_n, h_n, c_n;
    k_n = eff_k();
    h_n = eff_h();
    c_n = eff_c();
    r = $urandom_range(99);
    if (r < 20) return make_item(hwg_pkg::OP_WR_ERR, $urandom_range(k_n * c_n - 1));
    if (r < 35) return make_item(hwg_pkg::OP_WR_DERIV, $urandom_range(k_n * h_n - 1));
    if (r < 50) return make_item(hwg_pkg::OP_WR_ACT, $urandom_range(k_n * h_n - 1));
    if (r < 58) return make_item(hwg_pkg::OP_WR_WGT, $urandom_range(h_n * c_n - 1));
    if (r < 68) return make_item($urandom_range(3), $urandom_range(4095));
    if (r < 72) return make_item($urandom_range(1) ? OP_SPARE6 : OP_SPARE7, $urandom);
    if (r < 88) return make_item(hwg_pkg::OP_RD_GRAD, $urandom_range(h_n * h_n - 1));
    if (r < 92) return make_item(hwg_pkg::OP_RD_GRAD, $urandom_range(4095));
    return make_item(hwg_pkg::OP_COMPUTE, $urandom);
  endfunction

  typedef struct {
    logic [2:0]  op;
    logic [11:0] addr;
    logic [15:0] data;
    bit          typed;
  } dir_row_t;

  // directed table, run with K=2, H=2, C=1 and full gain
  dir_row_t dir_tab[] = '{
    '{hwg_pkg::OP_RD_GRAD,  12'd0,    16'h0000, 1'b1},  // gradient store clears on reset
    '{hwg_pkg::OP_RD_GRAD,  12'd3,    16'h0000, 1'b1},
    '{hwg_pkg::OP_WR_ERR,   12'd0,    16'h7FFF, 1'b0},
    '{hwg_pkg::OP_WR_ERR,   12'd1,    16'h8000, 1'b0},
    '{hwg_pkg::OP_WR_DERIV, 12'd0,    16'h8000, 1'b0},
    '{hwg_pkg::OP_WR_DERIV, 12'd1,    16'h8000, 1'b0},
    '{hwg_pkg::OP_WR_DERIV, 12'd2,    16'h7FFF, 1'b0},
    '{hwg_pkg::OP_WR_DERIV, 12'd3,    16'h0001, 1'b0},
    '{hwg_pkg::OP_WR_ACT,   12'd0,    16'h8000, 1'b0},
    '{hwg_pkg::OP_WR_ACT,   12'd1,    16'h8000, 1'b0},
    '{hwg_pkg::OP_WR_ACT,   12'd2,    16'hFFFF, 1'b0},
    '{hwg_pkg::OP_WR_ACT,   12'd3,    16'h7FFF, 1'b0},
    '{hwg_pkg::OP_WR_WGT,   12'd0,    16'h7FFF, 1'b0},
    '{hwg_pkg::OP_WR_WGT,   12'd1,    16'h8000, 1'b0},
    '{hwg_pkg::OP_WR_ERR,   12'd2048, 16'h1234, 1'b0},  // beyond the error store
    '{hwg_pkg::OP_WR_WGT,   12'd4095, 16'hABCD, 1'b0},  // beyond the weight store
    '{OP_SPARE6,            12'd5,    16'h5555, 1'b0},
    '{OP_SPARE7,            12'd4095, 16'hFFFF, 1'b0},
    '{hwg_pkg::OP_COMPUTE,  12'd0,    16'h0000, 1'b1},
    '{hwg_pkg::OP_RD_GRAD,  12'd0,    16'h0000, 1'b0},
    '{hwg_pkg::OP_RD_GRAD,  12'd1,    16'h0000, 1'b0},
    '{hwg_pkg::OP_RD_GRAD,  12'd2,    16'h0000, 1'b0},
    '{hwg_pkg::OP_RD_GRAD,  12'd3,    16'h0000, 1'b0},
    '{hwg_pkg::OP_RD_GRAD,  12'd4095, 16'h0000, 1'b1},  // beyond the gradient store
    '{hwg_pkg::OP_RD_GRAD,  12'd256,  16'h0000, 1'b1}
  };

  // ---------------------------------------------------------------------------
  // Result side: random stall, and check every transaction taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 27);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (grad_results_q.size() == 0) begin
        $error("result with nothing outstanding: kind %0d value %0d",
               out_data.kind, out_data.grad_value);
        fails++;
      end else begin
        want = grad_results_q.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          fails++;
        end
        if (out_data.grad_value !== want.grad_value) begin
          $error("grad_value: expected %0d, got %0d", want.grad_value,
                 out_data.grad_value);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n, phase, per_phase, rand_done, k_v, h_v;
    hwg_pkg::in_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(2, 2, 1, 65535, 0);
    foreach (dir_tab[n]) begin
      it.op   = dir_tab[n].op;
      it.addr = dir_tab[n].addr;
      it.data = dir_tab[n].data;
      send_item(it, dir_tab[n].typed);
    end
    drain();

    rand_done = 0;
    phase = 0;
    while (sent < 1300) begin
      per_phase = 60;
      case (phase)
        0: set_config(0, 0, 0, 0, 0);              // zero counts act as one
        1: begin                                   // largest rows and classes, last row
          set_config(1, 31, 15, 65535, 16);
          per_phase = 20;
        end
        2: set_config(3, 2, 2, 1, 31);             // select past the rows: all rows
        3: begin                                   // samples above the maximum
          set_config(511, 1, 1, 65535, 16);
          per_phase = 20;
        end
        default: begin
          k_v = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
          h_v = $urandom_range(1, 4);
          set_config(k_v, h_v, $urandom_range(0, 3),
                     ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(65535),
                     $urandom_range(0, h_v + 1));
        end
      endcase
      fill_operands();
      for (n = 0; n < per_phase; n++) begin
        // hold both sides busy through one long stretch
        calm = (rand_done >= 200 && rand_done < 320);
        send_item(random_item(), 1'b0);
        rand_done++;
      end
      calm = 1'b0;
      drain();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (fails == 0 && grad_results_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
